// File: design/ssp_pkg.sv
// ssp_pkg: shared types and constants of the soft-sphere pair force engine
// used by the channel interfaces, the arithmetic unit and the top level
package ssp_pkg;

	// operation codes of an input word
	typedef enum logic [1:0] {
		FN_LOAD = 2'd0,
		FN_PAIR = 2'd1,
		FN_WALL = 2'd2,
		FN_READ = 2'd3
	} func_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_BOX_X     = 3'd0,
		REG_BOX_Y     = 3'd1,
		REG_BOX_Z     = 3'd2,
		REG_K_REPEL   = 3'd3,
		REG_K_ATTRACT = 3'd4,
		REG_CUT_OUTER = 3'd5,
		REG_CUT_INNER = 3'd6,
		REG_K_WALL    = 3'd7
	} cfg_reg_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// fixed point scaling
	localparam int FSHIFT = 24;
	localparam int CUT_SHIFT = 12;
	localparam logic [46:0] PUSH_MAX = 47'h7FFF_FFFF_FFFF;

	// input word
	typedef struct packed {
		func_t              func;
		logic [9:0]         index_a;
		logic [9:0]         index_b;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0]        radius;
	} item_t;

	// result word
	typedef struct packed {
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic [46:0]        wall_push;
		logic               in_range;
		logic               saturated;
	} result_t;

	// shared multiply / divide / root unit
	typedef enum logic [1:0] {
		AOP_MUL  = 2'd0,
		AOP_DIV  = 2'd1,
		AOP_SQRT = 2'd2
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_ctl_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_LOAD,
		ST_RD_A,
		ST_RD_B,
		ST_CAP_B,
		ST_PAIR_PREP,
		ST_PAIR_PREP2,
		ST_WRAP_DIV,
		ST_WRAP_MUL,
		ST_SQ,
		ST_SQRT,
		ST_REGIME,
		ST_P_MUL,
		ST_P_DIV,
		ST_SC_MUL,
		ST_SC_DIV,
		ST_P_ACC,
		ST_WALL_PREP,
		ST_W_ACC,
		ST_WB_A,
		ST_WB_B,
		ST_DONE
	} seq_state_t;

endpackage

// File: design/ssp_in_if.sv
// ssp_in_if: input word channel, valid/ready handshake
// depends on ssp_pkg for the word type
interface ssp_in_if import ssp_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/ssp_out_if.sv
// ssp_out_if: result word channel, valid/ready handshake
// depends on ssp_pkg for the word type
interface ssp_out_if import ssp_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/ssp_arith.sv
// ssp_arith: shared bit-serial unit, 64x64 multiply, 128/64 divide, 66-bit root
// one bit (or bit pair) per cycle; depends on ssp_pkg
module ssp_arith import ssp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  arith_ctl_t  ctl,
	input  logic [63:0] opa,
	input  logic [63:0] opb,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	output logic [63:0] res_hi,
	output logic [63:0] res_lo,
	output logic        done
);

	localparam logic [6:0] WORD_STEPS = 7'd64;
	localparam logic [6:0] ROOT_STEPS = 7'd33;

	logic         busy_q;
	logic         done_q;
	logic [6:0]   cnt_q;
	arith_op_t    op_q;
	logic [127:0] prod_q;
	logic [127:0] mc_q;
	logic [63:0]  mp_q;
	logic [63:0]  rem_q;
	logic [63:0]  lo_q;
	logic [63:0]  dv_q;
	logic [63:0]  quo_q;
	logic [39:0]  srem_q;
	logic [33:0]  root_q;
	logic [65:0]  rad_q;

	logic         div_ovf;
	logic [63:0]  div_rs;
	logic         div_take;
	logic [39:0]  sq_rs;
	logic [39:0]  sq_trial;

	// divide overflow ends the operation at once with all ones
	assign div_ovf = (opb == '0) || (num_hi >= opb);

	// one step of divide and root
	always_comb begin
		div_rs = {rem_q[62:0], lo_q[63]};
		div_take = rem_q[63] || (div_rs >= dv_q);
		sq_rs = {srem_q[37:0], rad_q[65:64]};
		sq_trial = 40'({root_q, 2'b01});
	end

	// step count and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				if (ctl.op == AOP_DIV && div_ovf) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= (ctl.op == AOP_SQRT) ? ROOT_STEPS : WORD_STEPS;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q <= ctl.op;
			prod_q <= '0;
			mc_q <= {64'd0, opa};
			mp_q <= opb;
			rem_q <= num_hi;
			lo_q <= num_lo;
			dv_q <= opb;
			quo_q <= (div_ovf) ? '1 : '0;
			srem_q <= '0;
			root_q <= '0;
			rad_q <= {num_hi[1:0], num_lo};
		end else if (busy_q) begin
			unique case (op_q)
				AOP_MUL: begin
					if (mp_q[0]) prod_q <= prod_q + mc_q;
					mc_q <= {mc_q[126:0], 1'b0};
					mp_q <= {1'b0, mp_q[63:1]};
				end
				AOP_DIV: begin
					lo_q <= {lo_q[62:0], 1'b0};
					if (div_take) begin
						rem_q <= div_rs - dv_q;
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= div_rs;
						quo_q <= {quo_q[62:0], 1'b0};
					end
				end
				AOP_SQRT: begin
					rad_q <= {rad_q[63:0], 2'b00};
					if (sq_rs >= sq_trial) begin
						srem_q <= sq_rs - sq_trial;
						root_q <= {root_q[32:0], 1'b1};
					end else begin
						srem_q <= sq_rs;
						root_q <= {root_q[32:0], 1'b0};
					end
				end
				default: begin
					prod_q <= prod_q;
				end
			endcase
		end
	end

	// results
	always_comb begin
		res_hi = prod_q[127:64];
		unique case (op_q)
			AOP_MUL:  res_lo = prod_q[63:0];
			AOP_DIV:  res_lo = quo_q;
			AOP_SQRT: res_lo = 64'(root_q);
			default:  res_lo = '0;
		endcase
	end

	assign done = done_q;

endmodule

// File: design/soft_sphere_pair_force_top.sv
// soft_sphere_pair_force_top: soft-sphere pair force engine over a particle table
// one word at a time; pair and wall words use the shared bit-serial multiply/divide/root
// unit (19 word operations and one root per pair) after the table reads; indexes at or
// above MAX_PARTICLES are folded into the table by repeated subtraction; the result
// register frees the input
// reset clears control and loads register defaults; tables are undefined until loaded
module soft_sphere_pair_force_top import ssp_pkg::*; #(
	parameter int MAX_PARTICLES = 1024,
	parameter int FORCE_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ssp_in_if.sink                item,
	ssp_out_if.source             result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int FW = FORCE_WIDTH;
	localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int IW = (AW > 10) ? AW : 10;
	localparam logic [IW:0] MAX_V = (IW + 1)'(MAX_PARTICLES);
	localparam int PW = 3 * 32 + 31;
	localparam int CW = 3 * FW;
	localparam logic [63:0] FMAX = (64'd1 << (FW - 1)) - 64'd1;
	localparam logic signed [FW+1:0] SMAX = $signed((FW + 2)'(FMAX));
	localparam logic signed [FW+1:0] SMIN = -SMAX - 1;
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// saturating accumulate, returns {clipped, value}
	function automatic logic [FW:0] sat_add(logic signed [FW-1:0] acc,
			logic [FW-2:0] mag, logic sub);
		logic signed [FW+1:0] ext;
		logic signed [FW+1:0] mg;
		logic signed [FW+1:0] s;
		ext = (FW + 2)'(acc);
		mg = $signed({3'b000, mag});
		s = sub ? (ext - mg) : (ext + mg);
		if (s > SMAX) return {1'b1, SMAX[FW-1:0]};
		else if (s < SMIN) return {1'b1, SMIN[FW-1:0]};
		else return {1'b0, s[FW-1:0]};
	endfunction

	// accumulator to result field
	function automatic logic [47:0] to_field(logic signed [FW-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		return e[47:0];
	endfunction

	// configuration registers
	logic [30:0] box_x_q, box_y_q, box_z_q;
	logic [31:0] k_repel_q, k_attract_q, k_wall_q;
	logic [15:0] cut_outer_q, cut_inner_q;

	// sequencer
	seq_state_t state_q, state_d;
	logic       started_q;
	logic       out_valid_q;
	result_t    out_q;
	logic       out_free;

	// word and indexes
	item_t       item_q;
	logic [IW-1:0] ia_q, ib_q;

	// tables
	logic [PW-1:0] pos_mem [MAX_PARTICLES];
	logic [CW-1:0] acc_mem [MAX_PARTICLES];
	logic [PW-1:0] pos_rd_q;
	logic [CW-1:0] acc_rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          pos_we, acc_we;
	logic [CW-1:0] acc_wdata;

	// particle data
	logic signed [31:0] pa_x_q, pa_y_q, pa_z_q, pb_x_q, pb_y_q, pb_z_q;
	logic [30:0]        ra_q, rb_q;
	logic signed [FW-1:0] acc_a_q [3];
	logic signed [FW-1:0] acc_b_q [3];

	// pair and wall working registers
	logic signed [63:0] d_q [3];
	logic [1:0]         comp_q;
	logic [31:0]        dsum_q;
	logic [35:0]        da_q, dh_q;
	logic [63:0]        den_q;
	logic [65:0]        sum_q;
	logic [32:0]        n_q;
	logic [35:0]        m_q;
	logic               attract_q;
	logic [31:0]        ksel_q;
	logic [63:0]        msc_q;
	logic [63:0]        wq_q;
	logic [63:0]        num_hi_q, num_lo_q;
	logic [FW-2:0]      mag_q;
	logic               upper_q;
	logic               hit_q, sat_q;
	logic [46:0]        push_q;

	// arithmetic unit hookup
	arith_ctl_t  actl;
	logic [63:0] a_opa, a_opb, a_nhi, a_nlo, ar_hi, ar_lo;
	logic        a_done;
	logic        arith_state;

	// combinational helpers
	logic signed [63:0] d_cur;
	logic [63:0]        d_abs;
	logic [63:0]        len_cur;
	logic [63:0]        wrap_r;
	logic [47:0]        cut_o_prod, cut_i_prod;
	logic [63:0]        dsq;
	logic [61:0]        rsq;
	logic signed [33:0] wy, wr, wb;
	logic               w_below, w_above;
	logic [FW:0]        sa_a, sa_b, sa_w;
	logic               neg;
	logic [63:0]        mag64;

	ssp_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (actl),
		.opa    (a_opa),
		.opb    (a_opb),
		.num_hi (a_nhi),
		.num_lo (a_nlo),
		.res_hi (ar_hi),
		.res_lo (ar_lo),
		.done   (a_done)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= 31'd4194304;
			box_y_q <= 31'd4194304;
			box_z_q <= 31'd4194304;
			k_repel_q <= 32'd65536;
			k_attract_q <= 32'd0;
			cut_outer_q <= 16'd4915;
			cut_inner_q <= 16'd4505;
			k_wall_q <= 32'd65536;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_BOX_X:     box_x_q <= wr_data[30:0];
				REG_BOX_Y:     box_y_q <= wr_data[30:0];
				REG_BOX_Z:     box_z_q <= wr_data[30:0];
				REG_K_REPEL:   k_repel_q <= wr_data;
				REG_K_ATTRACT: k_attract_q <= wr_data;
				REG_CUT_OUTER: cut_outer_q <= wr_data[15:0];
				REG_CUT_INNER: cut_inner_q <= wr_data[15:0];
				REG_K_WALL:    k_wall_q <= wr_data;
			endcase
		end
	end

	// tables, one write and one registered read each
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[wr_addr] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z,
			item_q.radius};
		pos_rd_q <= pos_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[wr_addr] <= acc_wdata;
		acc_rd_q <= acc_mem[rd_addr];
	end

	// helpers
	always_comb begin
		d_cur = d_q[comp_q];
		d_abs = d_cur[63] ? (64'd0 - d_cur) : d_cur;
		len_cur = (comp_q == AX_X) ? 64'(box_x_q) : 64'(box_z_q);
		if (len_cur == '0) len_cur = 64'd1;
		wrap_r = d_abs - ar_lo;
		cut_o_prod = cut_outer_q * dsum_q;
		cut_i_prod = cut_inner_q * dsum_q;
		dsq = dsum_q * dsum_q;
		rsq = ra_q * ra_q;
		wy = 34'(pa_y_q);
		wr = $signed({3'b000, ra_q});
		wb = $signed({3'b000, box_y_q});
		w_below = wy < wr;
		w_above = wy > (wb - wr);
		neg = d_cur[63] ^ attract_q;
		sa_a = sat_add(acc_a_q[comp_q], mag_q, !neg);
		sa_b = sat_add(acc_b_q[comp_q], mag_q, neg);
		sa_w = sat_add(acc_a_q[AX_Y], mag_q, upper_q);
		mag64 = 64'(mag_q);
		arith_state = (state_q == ST_WRAP_DIV) || (state_q == ST_WRAP_MUL) ||
			(state_q == ST_SQ) || (state_q == ST_SQRT) || (state_q == ST_P_MUL) ||
			(state_q == ST_P_DIV) || (state_q == ST_SC_MUL) || (state_q == ST_SC_DIV);
	end

	assign out_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (item.valid) state_d = ST_REDUCE;
			ST_REDUCE: begin
				if (({1'b0, ia_q} < MAX_V) && ({1'b0, ib_q} < MAX_V))
					state_d = (item_q.func == FN_LOAD) ? ST_LOAD : ST_RD_A;
			end
			ST_LOAD: state_d = ST_DONE;
			ST_RD_A: state_d = ST_RD_B;
			ST_RD_B: state_d = ST_CAP_B;
			ST_CAP_B: begin
				unique case (item_q.func)
					FN_PAIR: state_d = ST_PAIR_PREP;
					FN_WALL: state_d = ST_WALL_PREP;
					default: state_d = ST_DONE;
				endcase
			end
			ST_PAIR_PREP: state_d = ST_PAIR_PREP2;
			ST_PAIR_PREP2: state_d = ST_WRAP_DIV;
			ST_WRAP_DIV: if (a_done) state_d = ST_WRAP_MUL;
			ST_WRAP_MUL: if (a_done) state_d = (comp_q == AX_X) ? ST_WRAP_DIV : ST_SQ;
			ST_SQ: if (a_done) state_d = (comp_q == AX_Z) ? ST_SQRT : ST_SQ;
			ST_SQRT: if (a_done) state_d = ST_REGIME;
			ST_REGIME: begin
				if (n_q != '0 && 36'(n_q) < da_q) state_d = ST_P_MUL;
				else state_d = ST_DONE;
			end
			ST_P_MUL: if (a_done) state_d = ST_P_DIV;
			ST_P_DIV: if (a_done) state_d = ST_SC_MUL;
			ST_SC_MUL: if (a_done) state_d = ST_SC_DIV;
			ST_SC_DIV: if (a_done) state_d = (item_q.func == FN_PAIR) ? ST_P_ACC : ST_W_ACC;
			ST_P_ACC: state_d = (comp_q == AX_Z) ? ST_WB_A : ST_P_MUL;
			ST_WALL_PREP: begin
				if (ra_q != '0 && (w_below || w_above)) state_d = ST_SC_MUL;
				else state_d = ST_DONE;
			end
			ST_W_ACC: state_d = ST_WB_A;
			ST_WB_A: state_d = (item_q.func == FN_PAIR) ? ST_WB_B : ST_DONE;
			ST_WB_B: state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: input ready, table ports and arithmetic requests
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		rd_addr = (state_q == ST_RD_A) ? ia_q[AW-1:0] : ib_q[AW-1:0];
		wr_addr = (state_q == ST_WB_B) ? ib_q[AW-1:0] : ia_q[AW-1:0];
		pos_we = (state_q == ST_LOAD);
		acc_we = (state_q == ST_LOAD) || (state_q == ST_WB_A) || (state_q == ST_WB_B);
		if (state_q == ST_WB_A) acc_wdata = {acc_a_q[AX_X], acc_a_q[AX_Y], acc_a_q[AX_Z]};
		else if (state_q == ST_WB_B)
			acc_wdata = {acc_b_q[AX_X], acc_b_q[AX_Y], acc_b_q[AX_Z]};
		else acc_wdata = '0;
		actl.start = arith_state && !started_q;
		actl.op = AOP_MUL;
		a_opa = '0;
		a_opb = '0;
		a_nhi = '0;
		a_nlo = '0;
		unique case (state_q)
			ST_WRAP_DIV: begin
				actl.op = AOP_DIV;
				a_nlo = {d_abs[62:0], 1'b0} + len_cur;
				a_opb = {len_cur[62:0], 1'b0};
			end
			ST_WRAP_MUL: begin
				a_opa = wq_q;
				a_opb = len_cur;
			end
			ST_SQ: begin
				a_opa = d_abs;
				a_opb = d_abs;
			end
			ST_SQRT: begin
				actl.op = AOP_SQRT;
				a_nhi = 64'(sum_q[65:64]);
				a_nlo = sum_q[63:0];
			end
			ST_P_MUL: begin
				a_opa = 64'(m_q);
				a_opb = d_abs;
			end
			ST_P_DIV: begin
				actl.op = AOP_DIV;
				a_nhi = num_hi_q;
				a_nlo = num_lo_q;
				a_opb = 64'(n_q);
			end
			ST_SC_MUL: begin
				a_opa = 64'(ksel_q);
				a_opb = msc_q;
			end
			ST_SC_DIV: begin
				actl.op = AOP_DIV;
				a_nhi = num_hi_q;
				a_nlo = num_lo_q;
				a_opb = den_q;
			end
			default: begin
				a_opa = '0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (a_done) started_q <= 1'b0;
			else if (actl.start) started_q <= 1'b1;
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					item_q <= item.data;
					ia_q <= IW'(item.data.index_a);
					ib_q <= IW'(item.data.index_b);
					hit_q <= 1'b0;
					sat_q <= 1'b0;
					push_q <= '0;
				end
			end
			// fold indexes into the table
			ST_REDUCE: begin
				if ({1'b0, ia_q} >= MAX_V) ia_q <= ia_q - MAX_V[IW-1:0];
				if ({1'b0, ib_q} >= MAX_V) ib_q <= ib_q - MAX_V[IW-1:0];
			end
			ST_LOAD: begin
				acc_a_q[AX_X] <= '0;
				acc_a_q[AX_Y] <= '0;
				acc_a_q[AX_Z] <= '0;
			end
			ST_RD_B: begin
				{pa_x_q, pa_y_q, pa_z_q, ra_q} <= pos_rd_q;
				acc_a_q[AX_X] <= acc_rd_q[3*FW-1:2*FW];
				acc_a_q[AX_Y] <= acc_rd_q[2*FW-1:FW];
				acc_a_q[AX_Z] <= acc_rd_q[FW-1:0];
			end
			ST_CAP_B: begin
				{pb_x_q, pb_y_q, pb_z_q, rb_q} <= pos_rd_q;
				acc_b_q[AX_X] <= acc_rd_q[3*FW-1:2*FW];
				acc_b_q[AX_Y] <= acc_rd_q[2*FW-1:FW];
				acc_b_q[AX_Z] <= acc_rd_q[FW-1:0];
			end
			// separations and contact distance
			ST_PAIR_PREP: begin
				d_q[AX_X] <= 64'(pb_x_q) - 64'(pa_x_q);
				d_q[AX_Y] <= 64'(pb_y_q) - 64'(pa_y_q);
				d_q[AX_Z] <= 64'(pb_z_q) - 64'(pa_z_q);
				dsum_q <= 32'(ra_q) + 32'(rb_q);
				sum_q <= '0;
				comp_q <= AX_X;
			end
			ST_PAIR_PREP2: begin
				da_q <= cut_o_prod[47:CUT_SHIFT];
				dh_q <= cut_i_prod[47:CUT_SHIFT];
				den_q <= dsq;
			end
			// periodic wrap of x and z
			ST_WRAP_DIV: if (a_done) wq_q <= ar_lo;
			ST_WRAP_MUL: begin
				if (a_done) begin
					d_q[comp_q] <= d_cur[63] ? (64'd0 - wrap_r) : wrap_r;
					comp_q <= (comp_q == AX_X) ? AX_Z : AX_X;
				end
			end
			// sum of squares
			ST_SQ: begin
				if (a_done) begin
					sum_q <= sum_q + 66'(ar_lo);
					if (comp_q != AX_Z) comp_q <= comp_q + 2'd1;
				end
			end
			ST_SQRT: if (a_done) n_q <= ar_lo[32:0];
			// force regime
			ST_REGIME: begin
				comp_q <= AX_X;
				if (n_q != '0 && 36'(n_q) < da_q) begin
					hit_q <= 1'b1;
					if (36'(n_q) <= 36'(dsum_q)) begin
						ksel_q <= k_repel_q;
						m_q <= 36'(dsum_q) - 36'(n_q);
						attract_q <= 1'b0;
					end else if (36'(n_q) < dh_q) begin
						ksel_q <= k_attract_q;
						m_q <= 36'(n_q) - 36'(dsum_q);
						attract_q <= 1'b1;
					end else begin
						ksel_q <= k_attract_q;
						m_q <= da_q - 36'(n_q);
						attract_q <= 1'b1;
					end
				end
			end
			ST_P_MUL: begin
				if (a_done) begin
					num_hi_q <= ar_hi;
					num_lo_q <= ar_lo;
				end
			end
			ST_P_DIV: if (a_done) msc_q <= ar_lo;
			// scale by 2^24 ahead of the stiffness divide
			ST_SC_MUL: begin
				if (a_done) begin
					num_hi_q <= {ar_hi[63-FSHIFT:0], ar_lo[63:64-FSHIFT]};
					num_lo_q <= {ar_lo[63-FSHIFT:0], {FSHIFT{1'b0}}};
				end
			end
			ST_SC_DIV: begin
				if (a_done) begin
					if (ar_lo > FMAX) begin
						mag_q <= FMAX[FW-2:0];
						sat_q <= 1'b1;
					end else begin
						mag_q <= ar_lo[FW-2:0];
					end
				end
			end
			// pair force into both accumulators
			ST_P_ACC: begin
				acc_a_q[comp_q] <= sa_a[FW-1:0];
				acc_b_q[comp_q] <= sa_b[FW-1:0];
				if (sa_a[FW] || sa_b[FW]) sat_q <= 1'b1;
				if (comp_q != AX_Z) comp_q <= comp_q + 2'd1;
			end
			// wall penetration
			ST_WALL_PREP: begin
				ksel_q <= k_wall_q;
				den_q <= 64'(rsq);
				upper_q <= !w_below;
				if (w_below) msc_q <= 64'(wr - wy);
				else msc_q <= 64'(wy + wr - wb);
				if (ra_q != '0 && (w_below || w_above)) hit_q <= 1'b1;
			end
			ST_W_ACC: begin
				acc_a_q[AX_Y] <= sa_w[FW-1:0];
				if (sa_w[FW]) sat_q <= 1'b1;
				if (upper_q) push_q <= (mag64 > 64'(PUSH_MAX)) ? PUSH_MAX : mag64[46:0];
			end
			// result word
			ST_DONE: begin
				if (out_free) begin
					out_q.force_x <= to_field(acc_a_q[AX_X]);
					out_q.force_y <= to_field(acc_a_q[AX_Y]);
					out_q.force_z <= to_field(acc_a_q[AX_Z]);
					out_q.wall_push <= push_q;
					out_q.in_range <= hit_q;
					out_q.saturated <= sat_q;
				end
			end
			default: begin
				comp_q <= comp_q;
			end
		endcase
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

endmodule

// File: dv/tb_soft_sphere_pair_force_top.sv
// tb_soft_sphere_pair_force_top: self-checking bench for the soft-sphere force engine
// drives loads, pair, wall and read words against a fixed point predictor of the table
// depends on ssp_pkg, ssp_in_if, ssp_out_if and soft_sphere_pair_force_top
`timescale 1ns / 100ps

module tb_soft_sphere_pair_force_top;
	import ssp_pkg::*;

	localparam longint FMAX = (64'sd1 <<< 47) - 1;

	// predictor of the particle table plus the queue of expected result words
	class force_scoreboard;
		logic [63:0] regs [8];
		longint px [1024], py [1024], pz [1024];
		logic [63:0] rad [1024];
		longint fx [1024], fy [1024], fz [1024];
		result_t pending [$];
		int errors;
		int matched;

		function new();
			regs[REG_BOX_X] = 4194304; regs[REG_BOX_Y] = 4194304;
			regs[REG_BOX_Z] = 4194304; regs[REG_K_REPEL] = 65536;
			regs[REG_K_ATTRACT] = 0; regs[REG_CUT_OUTER] = 4915;
			regs[REG_CUT_INNER] = 4505; regs[REG_K_WALL] = 65536;
			errors = 0;
			matched = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] v);
			if (idx == REG_BOX_X || idx == REG_BOX_Y || idx == REG_BOX_Z)
				regs[idx] = {33'b0, v[30:0]};
			else if (idx == REG_CUT_OUTER || idx == REG_CUT_INNER)
				regs[idx] = {48'b0, v[15:0]};
			else
				regs[idx] = {32'b0, v};
		endfunction

		// floor division, all ones when the divisor is zero or the quotient needs more than 64 bits
		function logic [63:0] div_clip(logic [127:0] num, logic [63:0] den);
			logic [127:0] q;
			if (den == 0) return '1;
			q = num / {64'b0, den};
			if (q[127:64] != 0) return '1;
			return q[63:0];
		endfunction

		function logic [63:0] root(logic [127:0] v);
			logic [127:0] rem, rt, trial;
			rem = 0;
			rt = 0;
			for (int i = 63; i >= 0; i--) begin
				rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
				trial = (rt << 2) | 128'd1;
				if (rem >= trial) begin
					rem = rem - trial;
					rt = (rt << 1) | 128'd1;
				end else begin
					rt = rt << 1;
				end
			end
			return rt[63:0];
		endfunction

		// floor(k*m*2^24/den) clipped to the force range
		function logic [63:0] scale(logic [63:0] k, logic [63:0] m, logic [63:0] den,
				inout bit sat);
			logic [63:0] q;
			q = div_clip(({64'b0, k} * {64'b0, m}) << FSHIFT, den);
			if (q > FMAX) begin
				q = FMAX;
				sat = 1;
			end
			return q;
		endfunction

		function void sat_add(inout longint acc, input longint d, inout bit sat);
			if (d > 0 && acc > FMAX - d) begin
				acc = FMAX;
				sat = 1;
			end else if (d < 0 && acc < -FMAX - 1 - d) begin
				acc = -FMAX - 1;
				sat = 1;
			end else begin
				acc = acc + d;
			end
		endfunction

		// nearest-image reduction of one periodic axis
		function longint wrap(longint d, logic [63:0] len);
			longint a, q, r;
			if (len == 0) len = 1;
			a = d < 0 ? -d : d;
			q = (2 * a + longint'(len)) / (2 * longint'(len));
			r = a - q * longint'(len);
			return d < 0 ? -r : r;
		endfunction

		function void comp(longint d, logic [63:0] m, logic [63:0] n, logic [63:0] k,
				logic [63:0] dd, bit attract, inout longint fa, inout longint fb,
				inout bit sat);
			logic [63:0] q, mag;
			longint ad, c;
			ad = d < 0 ? -d : d;
			q = div_clip({64'b0, m} * {64'b0, ad}, n);
			mag = scale(k, q, dd, sat);
			c = ((d < 0) != attract) ? -longint'(mag) : longint'(mag);
			sat_add(fa, -c, sat);
			sat_add(fb, c, sat);
		endfunction

		// work out the result word of one accepted input word
		function void note(item_t w);
			int a, b;
			bit hit, sat, attract;
			logic [63:0] push, dsum, da, dh, n, m, k, dd, r;
			longint dx, dy, dz, ax, ay, az, y, ri;
			logic [127:0] sq;
			result_t e;
			a = w.index_a;
			b = w.index_b;
			hit = 0;
			sat = 0;
			push = 0;
			case (w.func)
				FN_LOAD: begin
					px[a] = w.pos_x; py[a] = w.pos_y; pz[a] = w.pos_z;
					rad[a] = {33'b0, w.radius};
					fx[a] = 0; fy[a] = 0; fz[a] = 0;
				end
				FN_PAIR: begin
					dsum = rad[a] + rad[b];
					da = (regs[REG_CUT_OUTER] * dsum) >> CUT_SHIFT;
					dh = (regs[REG_CUT_INNER] * dsum) >> CUT_SHIFT;
					dx = wrap(px[b] - px[a], regs[REG_BOX_X]);
					dy = py[b] - py[a];
					dz = wrap(pz[b] - pz[a], regs[REG_BOX_Z]);
					ax = dx < 0 ? -dx : dx;
					ay = dy < 0 ? -dy : dy;
					az = dz < 0 ? -dz : dz;
					sq = {64'b0, ax} * ax + {64'b0, ay} * ay + {64'b0, az} * az;
					n = root(sq);
					if (n != 0 && n < da) begin
						if (n <= dsum) begin
							k = regs[REG_K_REPEL]; m = dsum - n; attract = 0;
						end else if (n < dh) begin
							k = regs[REG_K_ATTRACT]; m = n - dsum; attract = 1;
						end else begin
							k = regs[REG_K_ATTRACT]; m = da - n; attract = 1;
						end
						dd = dsum * dsum;
						comp(dx, m, n, k, dd, attract, fx[a], fx[b], sat);
						comp(dy, m, n, k, dd, attract, fy[a], fy[b], sat);
						comp(dz, m, n, k, dd, attract, fz[a], fz[b], sat);
						hit = 1;
					end
				end
				FN_WALL: begin
					r = rad[a];
					y = py[a];
					ri = longint'(r);
					if (r != 0) begin
						if (y < ri) begin
							m = scale(regs[REG_K_WALL], ri - y, r * r, sat);
							sat_add(fy[a], longint'(m), sat);
							hit = 1;
						end else if (y > longint'(regs[REG_BOX_Y]) - ri) begin
							m = scale(regs[REG_K_WALL], y + ri - longint'(regs[REG_BOX_Y]),
								r * r, sat);
							sat_add(fy[a], -longint'(m), sat);
							push = m;
							hit = 1;
						end
					end
				end
				default: ;
			endcase
			e.force_x = fx[a][47:0];
			e.force_y = fy[a][47:0];
			e.force_z = fz[a][47:0];
			e.wall_push = push[46:0];
			e.in_range = hit;
			e.saturated = sat;
			pending.push_back(e);
		endfunction

		function void cmp(string name, logic [47:0] e, logic [47:0] g);
			if (e !== g) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, e, g);
			end
		endfunction

		function void check(result_t g);
			result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, got %h", $realtime, g);
				return;
			end
			e = pending.pop_front();
			cmp("force_x", e.force_x, g.force_x);
			cmp("force_y", e.force_y, g.force_y);
			cmp("force_z", e.force_z, g.force_z);
			cmp("wall_push", {1'b0, e.wall_push}, {1'b0, g.wall_push});
			cmp("in_range", {47'b0, e.in_range}, {47'b0, g.in_range});
			cmp("saturated", {47'b0, e.saturated}, {47'b0, g.saturated});
			matched++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int send_idle;
	int recv_idle;
	int words_sent;
	int loaded [$];
	force_scoreboard sb;

	ssp_in_if item ();
	ssp_out_if result ();

	soft_sphere_pair_force_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: sample at the rising edge, stall at the falling edge
	initial begin
		result.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result.valid && result.ready)
				sb.check(result.data);
			@(negedge clk);
			result.ready = ($urandom_range(99) >= recv_idle);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(item_t w);
		if ($urandom_range(99) < send_idle) begin
			item.valid = 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
		item.valid = 1'b1;
		item.data = w;
		do @(posedge clk); while (!item.ready);
		sb.note(w);
		words_sent++;
		if (w.func == FN_LOAD) loaded.push_back(w.index_a);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = v;
		@(negedge clk);
		wr_en = 1'b0;
		sb.set_reg(idx, v);
	endtask

	task automatic drain();
		item.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	function automatic item_t word(func_t f, int a, int b, int x, int y, int z, int r);
		item_t w;
		w.func = f;
		w.index_a = 10'(a);
		w.index_b = 10'(b);
		w.pos_x = x;
		w.pos_y = y;
		w.pos_z = z;
		w.radius = 31'(r);
		return w;
	endfunction

	function automatic int pick_loaded();
		return loaded[$urandom_range(loaded.size() - 1)];
	endfunction

	// random word: mostly clustered loads and pairs between loaded particles
	function automatic item_t random_word(int pool []);
		item_t w;
		int sel;
		logic [191:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		w = raw[$bits(item_t)-1:0];
		sel = $urandom_range(99);
		if (sel < 20 || loaded.size() == 0) begin
			w.func = FN_LOAD;
			w.index_a = ($urandom_range(9) == 0) ? 10'($urandom) : 10'(pool[$urandom_range(15)]);
			if ($urandom_range(4) != 0) begin
				w.pos_x = $urandom_range(8 << 16);
				w.pos_y = $signed($urandom_range(12 << 16)) - (2 << 16);
				w.pos_z = $urandom_range(8 << 16);
				w.radius = 31'($urandom_range(1 << 15, 3 << 15));
			end else if ($urandom_range(1) == 0) begin
				w.radius = 31'($urandom_range(1, 31'h7FFF_FFFF));
			end
		end else if (sel < 70) begin
			w.func = FN_PAIR;
			w.index_a = 10'(pick_loaded());
			w.index_b = 10'(pick_loaded());
		end else begin
			w.func = (sel < 85) ? FN_WALL : FN_READ;
			w.index_a = 10'(pick_loaded());
		end
		return w;
	endfunction

	initial begin
		int pool [16];
		int per_phase;
		sb = new();
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_BOX_X;
		wr_data = '0;
		item.valid = 1'b0;
		item.data = '0;
		send_idle = 10;
		recv_idle = 73;
		words_sent = 0;
		foreach (pool[i]) pool[i] = $urandom_range(1023);
		pool[0] = 0;
		pool[1] = 1023;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// reset settings with attraction turned on
		write_reg(REG_K_ATTRACT, 32'd32768);

		// directed: contact, both attraction shapes, cutoff, coincidence, walls, extremes
		send(word(FN_LOAD, 0, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_LOAD, 1023, 0, 32'h0001_8000, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_PAIR, 0, 1023, 0, 0, 0, 0));
		send(word(FN_READ, 1023, 1023, -1, -1, -1, 31'h7FFF_FFFF));
		send(word(FN_LOAD, 2, 0, 32'h0003_1999, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_PAIR, 0, 2, 0, 0, 0, 0));
		send(word(FN_LOAD, 3, 0, 32'h0003_4CCC, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_PAIR, 0, 3, 0, 0, 0, 0));
		send(word(FN_LOAD, 4, 0, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_PAIR, 0, 4, 0, 0, 0, 0));
		send(word(FN_PAIR, 0, 0, 0, 0, 0, 0));
		send(word(FN_LOAD, 5, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h2_0000));
		send(word(FN_PAIR, 5, 0, 0, 0, 0, 0));
		send(word(FN_WALL, 0, 0, 0, 0, 0, 0));
		send(word(FN_LOAD, 6, 0, 32'h0002_0000, 32'h0000_8000, 32'h0002_0000, 32'h1_0000));
		send(word(FN_WALL, 6, 0, 0, 0, 0, 0));
		send(word(FN_LOAD, 7, 0, 32'h0002_0000, 32'h003F_8000, 32'h0002_0000, 32'h1_0000));
		send(word(FN_WALL, 7, 0, 0, 0, 0, 0));
		send(word(FN_LOAD, 8, 0, 32'h0002_0000, 32'h0000_1000, 32'h0002_0000, 0));
		send(word(FN_WALL, 8, 0, 0, 0, 0, 0));
		send(word(FN_LOAD, 9, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF));
		send(word(FN_LOAD, 10, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
		send(word(FN_PAIR, 10, 9, 0, 0, 0, 0));
		send(word(FN_LOAD, 11, 0, 32'h003F_8000, 32'h0001_0000, 32'h0001_0000, 32'h1_0000));
		send(word(FN_PAIR, 11, 0, 0, 0, 0, 0));

		per_phase = 130;
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) begin
				drain();
				// extremes: smallest x box, largest y box, zero z box, largest gains and outer cutoff ratio
				write_reg(REG_BOX_X, 32'd1);
				write_reg(REG_BOX_Y, 32'h7FFF_FFFF);
				write_reg(REG_BOX_Z, 32'h8000_0000);
				write_reg(REG_K_REPEL, 32'hFFFF_FFFF);
				write_reg(REG_K_ATTRACT, 32'hFFFF_FFFF);
				write_reg(REG_CUT_OUTER, 32'd65535);
				write_reg(REG_CUT_INNER, 32'd4096);
				write_reg(REG_K_WALL, 32'hFFFF_FFFF);
				send_idle = 73;
				recv_idle = 10;
			end else if (ph == 2) begin
				drain();
				write_reg(REG_BOX_X, 32'h7FFF_FFFF);
				write_reg(REG_BOX_Y, 32'd1);
				write_reg(REG_BOX_Z, 32'd1);
				write_reg(REG_K_REPEL, 32'd0);
				write_reg(REG_K_ATTRACT, 32'd0);
				write_reg(REG_CUT_OUTER, 32'd4096);
				write_reg(REG_CUT_INNER, 32'd65535);
				write_reg(REG_K_WALL, 32'd0);
				send_idle = 0;
				recv_idle = 0;
			end else if (ph == 3) begin
				drain();
				write_reg(REG_BOX_X, $urandom_range(1 << 18, 1 << 24));
				write_reg(REG_BOX_Y, $urandom_range(1 << 18, 1 << 24));
				write_reg(REG_BOX_Z, $urandom_range(1 << 18, 1 << 24));
				write_reg(REG_K_REPEL, $urandom);
				write_reg(REG_K_ATTRACT, $urandom);
				write_reg(REG_CUT_OUTER, $urandom_range(5000, 8192));
				write_reg(REG_CUT_INNER, $urandom_range(4096, 5000));
				write_reg(REG_K_WALL, $urandom);
			end
			for (int i = 0; i < per_phase; i++)
				send(random_word(pool));
		end

		drain();
		$display("words sent: %0d, results checked: %0d, over four register settings",
			words_sent, sb.matched);
		$display("covered load, pair, wall and read with sender and receiver stalls");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// File: sim.f
design/ssp_pkg.sv
design/ssp_in_if.sv
design/ssp_out_if.sv
design/ssp_arith.sv
design/soft_sphere_pair_force_top.sv
dv/tb_soft_sphere_pair_force_top.sv
